>>> hdl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  `ASSERT_HOLDS(label, clk, rst, !(cond))

`endif

>>> hdl/bfvc_pkg.sv
// Constants and types for the blob follow velocity controller.
package bfvc_pkg;

  localparam int unsigned X_W     = 12;
  localparam int unsigned AREA_W  = 20;
  localparam int unsigned PCT_W   = 6;
  localparam int unsigned SPEED_W = 15;
  localparam int unsigned CMD_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DATA_W  = 20;
  localparam int unsigned TICK_W  = 8;

  typedef logic [1:0] op_t;

  localparam op_t OP_BLOB      = 2'd0;
  localparam op_t OP_FRAME_END = 2'd1;
  localparam op_t OP_TICK      = 2'd2;

  typedef logic [IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_CENTER_BAND_PERCENT = 3'd0;
  localparam reg_idx_t REG_AREA_UPPER_LIMIT    = 3'd1;
  localparam reg_idx_t REG_AREA_LOWER_LIMIT    = 3'd2;
  localparam reg_idx_t REG_GOAL_AREA           = 3'd3;
  localparam reg_idx_t REG_GOAL_AREA_BAND      = 3'd4;
  localparam reg_idx_t REG_TURN_SPEED          = 3'd5;
  localparam reg_idx_t REG_DRIVE_SPEED         = 3'd6;

  localparam logic [PCT_W-1:0]   RST_CENTER_BAND_PERCENT = 6'd15;
  localparam logic [AREA_W-1:0]  RST_AREA_UPPER_LIMIT    = 20'd1800;
  localparam logic [AREA_W-1:0]  RST_AREA_LOWER_LIMIT    = 20'd200;
  localparam logic [AREA_W-1:0]  RST_GOAL_AREA           = 20'd900;
  localparam logic [AREA_W-1:0]  RST_GOAL_AREA_BAND      = 20'd80;
  localparam logic [SPEED_W-1:0] RST_TURN_SPEED          = 15'd77;
  localparam logic [SPEED_W-1:0] RST_DRIVE_SPEED         = 15'd102;

  // Search turn window in half-second ticks: more than 2 s, less than 14 s.
  localparam logic [TICK_W-1:0] SEARCH_FIRST_TICK = 8'd5;
  localparam logic [TICK_W-1:0] SEARCH_LAST_TICK  = 8'd27;
  localparam logic [TICK_W-1:0] TICK_MAX          = 8'd255;

  localparam logic [1:0] COUNT_SAT = 2'd2;

endpackage

>>> hdl/blob_follow_velocity_controller.sv
// Top level of the blob follow velocity controller.
//
//  channel | handshake            | words
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_ready  | operation, blob_x, blob_area, frame_width
//  out     | out_valid/ out_ready | drive_cmd, turn_cmd, tracking
//  config  | wr_en                | wr_index, wr_data (no wait, no read-back)
//
// One word per cycle while the output is taken; each word passes the input register and
// its result is registered in the controller state. The rate is set by the state update loop.
// Synchronous active-high reset restores the register defaults and zeroes state.
// A stalled result holds the update; one more input word is still taken.

`include "assert_macros.svh"

module blob_follow_velocity_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           operation,
  input  logic [bfvc_pkg::X_W-1:0]             blob_x,
  input  logic [bfvc_pkg::AREA_W-1:0]          blob_area,
  input  logic [bfvc_pkg::X_W-1:0]             frame_width,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bfvc_pkg::CMD_W-1:0]    drive_cmd,
  output logic signed [bfvc_pkg::CMD_W-1:0]    turn_cmd,
  output logic                                 tracking,
  input  logic                                 wr_en,
  input  logic [bfvc_pkg::IDX_W-1:0]           wr_index,
  input  logic [bfvc_pkg::DATA_W-1:0]          wr_data
);
  import bfvc_pkg::*;

  // Configuration registers.
  logic [PCT_W-1:0]   center_band_percent;
  logic [AREA_W-1:0]  area_upper_limit;
  logic [AREA_W-1:0]  area_lower_limit;
  logic [AREA_W-1:0]  goal_area;
  logic [AREA_W-1:0]  goal_area_band;
  logic [SPEED_W-1:0] turn_speed;
  logic [SPEED_W-1:0] drive_speed;

  // Input register stage.
  logic              s1_valid;
  op_t               s1_op;
  logic [X_W-1:0]    s1_x;
  logic [AREA_W-1:0] s1_area;
  logic [X_W-1:0]    s1_width;
  logic              advance;

  // Controller state. The command and tracking state doubles as the result
  // register: it only changes when a word advances into a free output slot.
  logic [1:0]              valid_blob_count, valid_blob_count_next;
  logic [X_W-1:0]          held_x, held_x_next;
  logic [AREA_W-1:0]       held_area, held_area_next;
  logic                    target_present, target_present_next;
  logic [TICK_W-1:0]       lost_ticks, lost_ticks_next;
  logic [CMD_W-1:0]        drive_value, drive_value_next;
  logic [CMD_W-1:0]        turn_value, turn_value_next;

  // Datapath terms.
  logic                    blob_ok;
  logic [X_W-2:0]          mid;
  logic [X_W+PCT_W-1:0]    band_scaled;      // width * percent, compared against 100 * offset
  logic signed [X_W:0]     off_left;         // mid - x
  logic signed [X_W:0]     off_right;        // x - mid
  logic signed [20:0]      off_left_x100;
  logic signed [20:0]      off_right_x100;
  logic signed [20:0]      band_cmp;
  logic                    turn_left;
  logic                    turn_right;
  logic [AREA_W:0]         area_plus_band;
  logic [AREA_W:0]         goal_plus_band;
  logic                    drive_fwd;
  logic                    drive_back;
  logic [TICK_W-1:0]       ticks_inc;
  logic [CMD_W-1:0]        turn_pos, turn_neg, drive_pos, drive_neg;

  // ---------------------------------------------------------------------------
  // Handshake: the input register moves on when the result slot is empty or
  // is being taken this cycle.
  // ---------------------------------------------------------------------------
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op    <= operation;
      s1_x     <= blob_x;
      s1_area  <= blob_area;
      s1_width <= frame_width;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration writes; an index past the list is dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      center_band_percent <= RST_CENTER_BAND_PERCENT;
      area_upper_limit    <= RST_AREA_UPPER_LIMIT;
      area_lower_limit    <= RST_AREA_LOWER_LIMIT;
      goal_area           <= RST_GOAL_AREA;
      goal_area_band      <= RST_GOAL_AREA_BAND;
      turn_speed          <= RST_TURN_SPEED;
      drive_speed         <= RST_DRIVE_SPEED;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CENTER_BAND_PERCENT: center_band_percent <= wr_data[PCT_W-1:0];
        REG_AREA_UPPER_LIMIT:    area_upper_limit    <= wr_data[AREA_W-1:0];
        REG_AREA_LOWER_LIMIT:    area_lower_limit    <= wr_data[AREA_W-1:0];
        REG_GOAL_AREA:           goal_area           <= wr_data[AREA_W-1:0];
        REG_GOAL_AREA_BAND:      goal_area_band      <= wr_data[AREA_W-1:0];
        REG_TURN_SPEED:          turn_speed          <= wr_data[SPEED_W-1:0];
        REG_DRIVE_SPEED:         drive_speed         <= wr_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath.
  // Blob filter: area strictly inside the limits.
  // Turn: with band = floor(W * pct / 100), "x < mid - band" is the same as
  // W * pct < 100 * (mid - x), so no divider is needed; 100 * d is built as
  // 64d + 32d + 4d. The right-hand test mirrors it with x - mid.
  // Drive: a < g - gb  <=>  a + gb < g, and a > g + gb, both unsigned.
  // ---------------------------------------------------------------------------
  assign blob_ok = (s1_area < area_upper_limit) && (s1_area > area_lower_limit);

  assign mid         = s1_width[X_W-1:1];
  assign band_scaled = s1_width * center_band_percent;
  assign off_left    = $signed({2'b00, mid}) - $signed({1'b0, held_x});
  assign off_right   = $signed({1'b0, held_x}) - $signed({2'b00, mid});

  assign off_left_x100  = (21'(off_left) <<< 6) + (21'(off_left) <<< 5)
                        + (21'(off_left) <<< 2);
  assign off_right_x100 = (21'(off_right) <<< 6) + (21'(off_right) <<< 5)
                        + (21'(off_right) <<< 2);
  assign band_cmp       = $signed({3'b000, band_scaled});

  assign turn_left  = band_cmp < off_left_x100;
  assign turn_right = band_cmp < off_right_x100;

  assign area_plus_band = {1'b0, held_area} + {1'b0, goal_area_band};
  assign goal_plus_band = {1'b0, goal_area} + {1'b0, goal_area_band};
  assign drive_fwd      = area_plus_band < {1'b0, goal_area};
  assign drive_back     = {1'b0, held_area} > goal_plus_band;

  assign turn_pos  = {1'b0, turn_speed};
  assign turn_neg  = CMD_W'(0) - turn_pos;
  assign drive_pos = {1'b0, drive_speed};
  assign drive_neg = CMD_W'(0) - drive_pos;

  // Lost-tick counter saturates at its top value.
  assign ticks_inc = (lost_ticks == TICK_MAX) ? lost_ticks : lost_ticks + 1'b1;

  always_comb begin
    valid_blob_count_next = valid_blob_count;
    held_x_next           = held_x;
    held_area_next        = held_area;
    target_present_next   = target_present;
    lost_ticks_next       = lost_ticks;
    drive_value_next      = drive_value;
    turn_value_next       = turn_value;

    unique case (s1_op)
      OP_BLOB: begin
        if (blob_ok) begin
          // Hold the first valid blob of the frame, count up to two.
          if (valid_blob_count == 2'd0) begin
            held_x_next    = s1_x;
            held_area_next = s1_area;
          end
          if (valid_blob_count != COUNT_SAT) begin
            valid_blob_count_next = valid_blob_count + 1'b1;
          end
        end
      end
      OP_FRAME_END: begin
        if (valid_blob_count == 2'd1) begin
          target_present_next = 1'b1;
          lost_ticks_next     = '0;
          priority if (turn_left) begin
            turn_value_next = turn_pos;
          end else if (turn_right) begin
            turn_value_next = turn_neg;
          end else begin
            turn_value_next = '0;
          end
          priority if (drive_fwd) begin
            drive_value_next = drive_pos;
          end else if (drive_back) begin
            drive_value_next = drive_neg;
          end else begin
            drive_value_next = '0;
          end
        end else begin
          // No target or several: drop tracking, keep commands.
          target_present_next = 1'b0;
        end
        valid_blob_count_next = '0;
      end
      OP_TICK: begin
        if (!target_present) begin
          lost_ticks_next  = ticks_inc;
          drive_value_next = '0;
          if (ticks_inc >= SEARCH_FIRST_TICK && ticks_inc <= SEARCH_LAST_TICK) begin
            turn_value_next = turn_pos;
          end else begin
            turn_value_next = '0;
          end
        end
      end
      default: ;  // unused code: state holds, current values answered
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_blob_count <= '0;
      held_x           <= '0;
      held_area        <= '0;
      target_present   <= 1'b0;
      lost_ticks       <= '0;
      drive_value      <= '0;
      turn_value       <= '0;
    end else if (advance) begin
      valid_blob_count <= valid_blob_count_next;
      held_x           <= held_x_next;
      held_area        <= held_area_next;
      target_present   <= target_present_next;
      lost_ticks       <= lost_ticks_next;
      drive_value      <= drive_value_next;
      turn_value       <= turn_value_next;
    end
  end

  assign drive_cmd = $signed(drive_value);
  assign turn_cmd  = $signed(turn_value);
  assign tracking  = target_present;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `ASSERT_HOLDS(a_track_clears_ticks, clk, rst, target_present |-> (lost_ticks == '0))
  `ASSERT_NEVER(a_count_saturates, clk, rst, valid_blob_count == 2'd3)
  `ASSERT_HOLDS(a_result_drains, clk, rst, (out_valid && out_ready && !advance) |=> !out_valid)

endmodule
